FILE: rtl/core/char_lcd_nibble_sequencer_unit_macros.svh
// assertion helpers used by clns_ctrl
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CLNS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define CLNS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define CLNS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CLNS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/clns_pkg.sv
package clns_pkg;

    localparam int MAX_DIGITS  = 10;
    localparam int NUM_W       = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int CNT_W       = $clog2(NUM_W);
    localparam int IDX_W       = $clog2(NUM_DIGITS);
    localparam int HOLD_W      = 6;
    localparam int INIT_BYTES  = 9;
    localparam int CLEAR_BYTES = 2;

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_DATA   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;
    localparam logic [2:0] OP_PRINT  = 3'd5;

    localparam logic [1:0] ROW_ONE = 2'd1;
    localparam logic [1:0] ROW_TWO = 2'd2;

    localparam logic [1:0] STEP_HI_EN  = 2'd0;
    localparam logic [1:0] STEP_HI_LOW = 2'd1;
    localparam logic [1:0] STEP_LO_EN  = 2'd2;
    localparam logic [1:0] STEP_LO_LOW = 2'd3;

    localparam logic [HOLD_W-1:0] HOLD_EN_HIGH = 6'd1;
    localparam logic [HOLD_W-1:0] HOLD_EN_LOW  = 6'd2;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] DDRAM_ROW1   = 8'h80;
    localparam logic [7:0] DDRAM_ROW2   = 8'hC0;
    localparam logic [7:0] DISP_CLEAR   = 8'h01;
    localparam logic [7:0] LCD_HOME     = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CONV,
        S_SKIP,
        S_SEND
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic skip;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_print;
        logic no_output;
        logic conv_done;
        logic skip_done;
        logic final_step;
    } t_sts;

    typedef struct packed {
        logic [7:0]        data;
        logic [HOLD_W-1:0] extra;
    } t_byte_ent;

    function automatic t_byte_ent init_entry(input logic [IDX_W-1:0] idx);
        t_byte_ent e;
        e.extra = '0;
        case (idx)
            4'd0: begin e.data = DISP_CLEAR; e.extra = 6'd2;  end
            4'd1: begin e.data = LCD_HOME;   e.extra = 6'd35; end
            4'd2: begin e.data = 8'h03;      e.extra = 6'd5;  end
            4'd3: e.data = 8'h33;
            4'd4: e.data = 8'h32;
            4'd5: e.data = 8'h28;
            4'd6: e.data = 8'h0C;
            4'd7: e.data = 8'h06;
            default: begin e.data = DISP_CLEAR; e.extra = 6'd2; end
        endcase
        return e;
    endfunction

    function automatic t_byte_ent clear_entry(input logic [IDX_W-1:0] idx);
        t_byte_ent e;
        e.extra = '0;
        case (idx)
            4'd0: begin e.data = DISP_CLEAR; e.extra = 6'd2; end
            default: e.data = LCD_HOME;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/core/clns_if.sv
interface clns_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  value_byte;
    logic [1:0]  row;
    logic [7:0]  column;
    logic [31:0] number;

    modport source (
        output valid, opcode, value_byte, row, column, number,
        input  ready
    );
    modport sink (
        input  valid, opcode, value_byte, row, column, number,
        output ready
    );
endinterface

interface clns_step_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic [3:0] nibble;
    logic [5:0] hold_ms;
    logic       last;

    modport source (
        output valid, reg_select, read_write, enable, nibble, hold_ms, last,
        input  ready
    );
    modport sink (
        input  valid, reg_select, read_write, enable, nibble, hold_ms, last,
        output ready
    );
endinterface

FILE: rtl/core/clns_datapath.sv
module clns_datapath (
    input  logic                         i_clk,
    input  logic [2:0]                   i_opcode,
    input  logic [7:0]                   i_value_byte,
    input  logic [1:0]                   i_row,
    input  logic [7:0]                   i_column,
    input  logic [clns_pkg::NUM_W-1:0]   i_number,
    input  clns_pkg::t_cmd               i_cmd,
    output clns_pkg::t_sts               o_sts,
    output logic                         o_reg_select,
    output logic                         o_enable,
    output logic [3:0]                   o_nibble,
    output logic [clns_pkg::HOLD_W-1:0]  o_hold_ms,
    output logic                         o_last
);

    logic [2:0]                        r_op;
    logic [7:0]                        r_val;
    logic                              r_no_out;
    logic [clns_pkg::NUM_W-1:0]        r_bin;
    logic [clns_pkg::BCD_W-1:0]        r_bcd;
    logic [clns_pkg::CNT_W-1:0]        r_cnt;
    logic [clns_pkg::IDX_W-1:0]        r_idx;
    logic [1:0]                        r_step;
    logic                              r_rs;
    logic                              r_en;
    logic [3:0]                        r_nib;
    logic [clns_pkg::HOLD_W-1:0]       r_hold;
    logic                              r_last;

    logic [7:0]                        n_val;
    logic                              n_no_out;
    logic [clns_pkg::BCD_W-1:0]        adj;
    logic [3:0]                        digit;
    logic                              high_nonzero;
    clns_pkg::t_byte_ent               cur;
    logic                              last_byte;
    logic                              cur_rs;
    logic                              cur_en;
    logic [3:0]                        cur_nib;
    logic [clns_pkg::HOLD_W-1:0]       cur_hold;

    // request decode at load time
    always_comb begin
        if (i_opcode == clns_pkg::OP_CURSOR) begin
            n_val = ((i_row == clns_pkg::ROW_TWO) ? clns_pkg::DDRAM_ROW2 : clns_pkg::DDRAM_ROW1)
                    + i_column - 8'd1;
        end else begin
            n_val = i_value_byte;
        end
        n_no_out = (i_opcode > clns_pkg::OP_PRINT)
                || ((i_opcode == clns_pkg::OP_CURSOR)
                    && (i_row != clns_pkg::ROW_ONE) && (i_row != clns_pkg::ROW_TWO));
    end

    // double dabble correction, one add-3 per bcd digit
    always_comb begin
        for (int k = 0; k < clns_pkg::NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    assign digit = r_bcd[{r_idx, 2'b00} +: 4];

    // digits beyond the printed width mean no leading-zero suppression
    always_comb begin
        high_nonzero = 1'b0;
        for (int k = 0; k < clns_pkg::NUM_DIGITS; k++) begin
            if (k >= clns_pkg::MAX_DIGITS) begin
                high_nonzero = high_nonzero | (|r_bcd[4*k +: 4]);
            end
        end
    end

    always_comb begin
        cur.data  = r_val;
        cur.extra = '0;
        last_byte = 1'b1;
        case (r_op)
            clns_pkg::OP_INIT: begin
                cur       = clns_pkg::init_entry(r_idx);
                last_byte = (r_idx == clns_pkg::IDX_W'(clns_pkg::INIT_BYTES - 1));
            end
            clns_pkg::OP_CLEAR: begin
                cur       = clns_pkg::clear_entry(r_idx);
                last_byte = (r_idx == clns_pkg::IDX_W'(clns_pkg::CLEAR_BYTES - 1));
            end
            clns_pkg::OP_PRINT: begin
                cur.data  = clns_pkg::ASCII_ZERO | {4'h0, digit};
                last_byte = (r_idx == '0);
            end
            default: begin
                cur.data  = r_val;
                last_byte = 1'b1;
            end
        endcase
    end

    always_comb begin
        cur_rs  = (r_op == clns_pkg::OP_DATA) || (r_op == clns_pkg::OP_PRINT);
        cur_en  = (r_step == clns_pkg::STEP_HI_EN) || (r_step == clns_pkg::STEP_LO_EN);
        cur_nib = ((r_step == clns_pkg::STEP_LO_EN) || (r_step == clns_pkg::STEP_LO_LOW))
                  ? cur.data[3:0] : cur.data[7:4];
        if (r_step == clns_pkg::STEP_LO_LOW) begin
            cur_hold = clns_pkg::HOLD_EN_LOW + cur.extra;
        end else if (r_step == clns_pkg::STEP_HI_LOW) begin
            cur_hold = clns_pkg::HOLD_EN_LOW;
        end else begin
            cur_hold = clns_pkg::HOLD_EN_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_val    <= n_val;
            r_no_out <= n_no_out;
            r_bin    <= i_number;
            r_bcd    <= '0;
            r_cnt    <= '0;
            r_idx    <= (i_opcode == clns_pkg::OP_PRINT)
                        ? clns_pkg::IDX_W'(clns_pkg::MAX_DIGITS - 1) : '0;
            r_step   <= clns_pkg::STEP_HI_EN;
        end else if (i_cmd.conv) begin
            r_bcd <= {adj[clns_pkg::BCD_W-2:0], r_bin[clns_pkg::NUM_W-1]};
            r_bin <= {r_bin[clns_pkg::NUM_W-2:0], 1'b0};
            r_cnt <= r_cnt + clns_pkg::CNT_W'(1);
        end else if (i_cmd.skip) begin
            r_idx <= r_idx - clns_pkg::IDX_W'(1);
        end else if (i_cmd.emit) begin
            if (r_step == clns_pkg::STEP_LO_LOW) begin
                r_step <= clns_pkg::STEP_HI_EN;
                r_idx  <= (r_op == clns_pkg::OP_PRINT) ? r_idx - clns_pkg::IDX_W'(1)
                                                       : r_idx + clns_pkg::IDX_W'(1);
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_rs   <= cur_rs;
            r_en   <= cur_en;
            r_nib  <= cur_nib;
            r_hold <= cur_hold;
            r_last <= last_byte && (r_step == clns_pkg::STEP_LO_LOW);
        end
    end

    assign o_sts.is_print   = (r_op == clns_pkg::OP_PRINT);
    assign o_sts.no_output  = r_no_out;
    assign o_sts.conv_done  = (r_cnt == clns_pkg::CNT_W'(clns_pkg::NUM_W - 1));
    assign o_sts.skip_done  = (r_idx == '0) || (digit != 4'd0) || high_nonzero;
    assign o_sts.final_step = last_byte && (r_step == clns_pkg::STEP_LO_LOW);

    assign o_reg_select = r_rs;
    assign o_enable     = r_en;
    assign o_nibble     = r_nib;
    assign o_hold_ms    = r_hold;
    assign o_last       = r_last;

endmodule

FILE: rtl/core/clns_ctrl.sv
`include "char_lcd_nibble_sequencer_unit_macros.svh"

module clns_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output clns_pkg::t_cmd  o_cmd,
    input  clns_pkg::t_sts  i_sts
);

    clns_pkg::t_state r_state;
    clns_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    clns_pkg::t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clns_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            clns_pkg::S_IDLE: begin
                if (i_in_valid) n_state = clns_pkg::S_START;
            end
            clns_pkg::S_START: begin
                if (i_sts.no_output)     n_state = clns_pkg::S_IDLE;
                else if (i_sts.is_print) n_state = clns_pkg::S_CONV;
                else                     n_state = clns_pkg::S_SEND;
            end
            clns_pkg::S_CONV: begin
                if (i_sts.conv_done) n_state = clns_pkg::S_SKIP;
            end
            clns_pkg::S_SKIP: begin
                if (i_sts.skip_done) n_state = clns_pkg::S_SEND;
            end
            clns_pkg::S_SEND: begin
                if (cmd.emit && i_sts.final_step) n_state = clns_pkg::S_IDLE;
            end
            default: n_state = clns_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == clns_pkg::S_IDLE);
        cmd.load   = (r_state == clns_pkg::S_IDLE) && i_in_valid;
        cmd.conv   = (r_state == clns_pkg::S_CONV);
        cmd.skip   = (r_state == clns_pkg::S_SKIP) && !i_sts.skip_done;
        // a new beat goes out once the output register is empty or draining
        cmd.emit   = (r_state == clns_pkg::S_SEND) && (!r_out_valid || i_out_ready);
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    `CLNS_ASSERT_IMP(a_emit_needs_slot, i_clk, i_rst_n, cmd.emit, (!r_out_valid || i_out_ready))
    `CLNS_ASSERT_NXT(a_final_to_idle, i_clk, i_rst_n, (cmd.emit && i_sts.final_step), (r_state == clns_pkg::S_IDLE))
    `CLNS_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, (i_in_valid && o_in_ready), (r_state == clns_pkg::S_START))
    `CLNS_ASSERT_NXT(a_emit_shows, i_clk, i_rst_n, cmd.emit, r_out_valid)

endmodule

FILE: rtl/core/char_lcd_nibble_sequencer_unit.sv
// 4-bit character lcd pin sequencer
// i_req carries one request per beat: init, command byte, data byte, clear,
// set cursor or print number. o_step carries one pin step per beat: rs, rw,
// en level, the d7..d4 nibble, the hold time in ms and a last flag on the
// final step of the request. each byte goes out as four steps, high nibble
// first. set cursor on a row other than 1 or 2 and opcodes 6 and 7 give no
// steps at all.
// requests are handled one at a time; i_req.ready is high only when idle.
// after acceptance the request passes the start state; steps then go out one
// per cycle while o_step.ready stays high: command/data/cursor take 4 steps,
// clear 8 steps, init 36 steps. print number first runs a double dabble
// conversion of the 32-bit number, then a skip of up to 9 leading zeros,
// then 4 steps per digit.
// a stalled receiver freezes the sequence; the step in the output register
// is held. the next request is taken while the final step still waits.
// reset (synchronous, active low) returns to idle and drops o_step.valid.
module char_lcd_nibble_sequencer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clns_req_if.sink          i_req,
    clns_step_if.source       o_step
);

    clns_pkg::t_cmd cmd;
    clns_pkg::t_sts sts;

    clns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_step.valid),
        .i_out_ready (o_step.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    clns_datapath u_datapath (
        .i_clk        (i_clk),
        .i_opcode     (i_req.opcode),
        .i_value_byte (i_req.value_byte),
        .i_row        (i_req.row),
        .i_column     (i_req.column),
        .i_number     (i_req.number),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_reg_select (o_step.reg_select),
        .o_enable     (o_step.enable),
        .o_nibble     (o_step.nibble),
        .o_hold_ms    (o_step.hold_ms),
        .o_last       (o_step.last)
    );

    assign o_step.read_write = 1'b0;

endmodule

FILE: tb/char_lcd_nibble_sequencer_checker.sv
module char_lcd_nibble_sequencer_checker
    import clns_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    clns_req_if   req,
    clns_step_if  step,
    output int    o_pending,
    output int    o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       en;
        logic [3:0] nib;
        logic [5:0] hold;
        logic       last;
    } pin_step_t;

    pin_step_t pin_step_q[$];
    int        mismatch_cnt = 0;
    int        beat_cnt = 0;

    assign o_mismatches = mismatch_cnt;

    // four pin steps per byte, any trailing delay goes on the final enable-low step
    function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                       input logic [5:0] extra_ms);
        pin_step_t s;
        s.rs   = rs;
        s.rw   = 1'b0;
        s.last = 1'b0;
        s.en   = 1'b1; s.nib = b[7:4]; s.hold = 6'd1;
        pin_step_q.push_back(s);
        s.en   = 1'b0; s.hold = 6'd2;
        pin_step_q.push_back(s);
        s.en   = 1'b1; s.nib = b[3:0]; s.hold = 6'd1;
        pin_step_q.push_back(s);
        s.en   = 1'b0; s.hold = 6'd2 + extra_ms;
        pin_step_q.push_back(s);
    endfunction

    function automatic void queue_decimal(input logic [31:0] num);
        logic [3:0]  dig [MAX_DIGITS];
        logic [31:0] v;
        int          n;
        v = num;
        n = 0;
        do begin
            dig[n] = 4'(v % 32'd10);
            v = v / 32'd10;
            n++;
        end while (v != 0 && n < MAX_DIGITS);
        for (int i = n - 1; i >= 0; i--)
            queue_byte(1'b1, ASCII_ZERO + {4'd0, dig[i]}, 6'd0);
    endfunction

    function automatic void expand_request(input logic [2:0] op, input logic [7:0] vb,
                                           input logic [1:0] row, input logic [7:0] col,
                                           input logic [31:0] num);
        int        base;
        pin_step_t s;
        base = pin_step_q.size();
        case (op)
            OP_INIT: begin
                queue_byte(1'b0, 8'h01, 6'd2);
                queue_byte(1'b0, 8'h80, 6'd35);
                queue_byte(1'b0, 8'h03, 6'd5);
                queue_byte(1'b0, 8'h33, 6'd0);
                queue_byte(1'b0, 8'h32, 6'd0);
                queue_byte(1'b0, 8'h28, 6'd0);
                queue_byte(1'b0, 8'h0C, 6'd0);
                queue_byte(1'b0, 8'h06, 6'd0);
                queue_byte(1'b0, 8'h01, 6'd2);
            end
            OP_CMD:  queue_byte(1'b0, vb, 6'd0);
            OP_DATA: queue_byte(1'b1, vb, 6'd0);
            OP_CLEAR: begin
                queue_byte(1'b0, 8'h01, 6'd2);
                queue_byte(1'b0, 8'h80, 6'd0);
            end
            OP_CURSOR: begin
                if (row == ROW_ONE)
                    queue_byte(1'b0, 8'h80 + col - 8'd1, 6'd0);
                else if (row == ROW_TWO)
                    queue_byte(1'b0, 8'hC0 + col - 8'd1, 6'd0);
            end
            OP_PRINT: queue_decimal(num);
            default: ;
        endcase
        if (pin_step_q.size() > base) begin
            s = pin_step_q.pop_back();
            s.last = 1'b1;
            pin_step_q.push_back(s);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        pin_step_t got;
        pin_step_t want;
        if (!i_rst_n) begin
            pin_step_q.delete();
            o_pending <= 0;
        end else begin
            if (req.valid && req.ready)
                expand_request(req.opcode, req.value_byte, req.row, req.column, req.number);
            if (step.valid && step.ready) begin
                got = '{step.reg_select, step.read_write, step.enable, step.nibble,
                        step.hold_ms, step.last};
                if (pin_step_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("[%0t] beat %0d: unexpected step rs=%0d rw=%0d en=%0d d=%h hold=%0d last=%0d",
                                 $realtime, beat_cnt, got.rs, got.rw, got.en, got.nib,
                                 got.hold, got.last);
                end else begin
                    want = pin_step_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("[%0t] beat %0d: expected rs=%0d rw=%0d en=%0d d=%h hold=%0d last=%0d",
                                     $realtime, beat_cnt, want.rs, want.rw, want.en, want.nib,
                                     want.hold, want.last);
                            $display("%28s got rs=%0d rw=%0d en=%0d d=%h hold=%0d last=%0d",
                                     "", got.rs, got.rw, got.en, got.nib, got.hold, got.last);
                        end
                    end
                end
                beat_cnt++;
            end
            o_pending <= pin_step_q.size();
        end
    end

endmodule

FILE: tb/tb_char_lcd_nibble_sequencer_unit.sv
module tb_char_lcd_nibble_sequencer_unit;
    import clns_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_REQS = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm = 1'b0;

    int pending;
    int mismatches;
    int quiet_cycles = 0;
    int req_cnt = 0;
    int silent_cnt = 0;
    int beat_cnt = 0;

    clns_req_if  req_ch();
    clns_step_if step_ch();

    char_lcd_nibble_sequencer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_step  (step_ch)
    );

    char_lcd_nibble_sequencer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_ch),
        .step         (step_ch),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always #6 i_clk = ~i_clk;

    // returns at the edge that took the beat
    task automatic send_request(input logic [2:0] op, input logic [7:0] vb,
                                input logic [1:0] row, input logic [7:0] col,
                                input logic [31:0] num);
        while (!calm && $urandom_range(0, 99) < 14) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.value_byte <= vb;
        req_ch.row        <= row;
        req_ch.column     <= col;
        req_ch.number     <= num;
        do @(posedge i_clk); while (!req_ch.ready);
        req_cnt++;
        if (op > OP_PRINT || (op == OP_CURSOR && row != ROW_ONE && row != ROW_TWO))
            silent_cnt++;
    endtask

    task automatic drain_steps();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [31:0] pick_number();
        logic [31:0] p;
        int          k;
        p = 32'd1;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(0, 99999);
            2: return $urandom;
            default: begin
                // around a power of ten, where the digit count changes
                k = $urandom_range(0, 9);
                for (int i = 0; i < k; i++)
                    p = p * 32'd10;
                return p - 32'd1 + $urandom_range(0, 2);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (step_ch.valid && step_ch.ready)
                beat_cnt <= beat_cnt + 1;
            if ((req_ch.valid && req_ch.ready) || (step_ch.valid && step_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no beat for %0d cycles, %0d steps outstanding",
                         $realtime, QUIET_LIMIT, pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // receiver side
    initial begin
        step_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            step_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
        end
    end

    initial begin
        int          counted;
        logic [2:0]  op;
        logic [1:0]  row;
        int          pick;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_INIT;
        req_ch.value_byte <= 8'd0;
        req_ch.row        <= 2'd0;
        req_ch.column     <= 8'd0;
        req_ch.number     <= 32'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        send_request(OP_INIT,   8'($urandom), 2'($urandom), 8'($urandom), $urandom);
        send_request(OP_CLEAR,  8'($urandom), 2'($urandom), 8'($urandom), $urandom);
        send_request(OP_CMD,    8'h00, 2'd0, 8'd0, 32'd0);
        send_request(OP_CMD,    8'hFF, 2'd3, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_DATA,   8'h00, 2'd0, 8'd0, 32'd0);
        send_request(OP_DATA,   8'hFF, 2'd3, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_DATA,   8'hA5, 2'd1, 8'h5A, 32'h5A5A_A5A5);
        send_request(OP_CURSOR, 8'd0, ROW_ONE, 8'd1, 32'd0);
        send_request(OP_CURSOR, 8'd0, ROW_ONE, 8'd0, 32'd0);
        send_request(OP_CURSOR, 8'd0, ROW_ONE, 8'd255, 32'd0);
        send_request(OP_CURSOR, 8'd0, ROW_TWO, 8'd1, 32'd0);
        send_request(OP_CURSOR, 8'd0, ROW_TWO, 8'd0, 32'd0);
        send_request(OP_CURSOR, 8'd0, ROW_TWO, 8'd255, 32'd0);
        send_request(OP_CURSOR, 8'd0, 2'd0, 8'd5, 32'd0);
        send_request(OP_CURSOR, 8'd0, 2'd3, 8'd5, 32'd0);
        send_request(OP_PRINT,  8'd0, 2'd0, 8'd0, 32'd0);
        send_request(OP_PRINT,  8'd0, 2'd0, 8'd0, 32'd9);
        send_request(OP_PRINT,  8'd0, 2'd0, 8'd0, 32'd10);
        send_request(OP_PRINT,  8'd0, 2'd0, 8'd0, 32'd1000000000);
        send_request(OP_PRINT,  8'd0, 2'd0, 8'd0, 32'd1234567890);
        send_request(OP_PRINT,  8'd0, 2'd0, 8'd0, 32'hFFFF_FFFF);
        send_request(3'd6,      8'($urandom), 2'($urandom), 8'($urandom), $urandom);
        send_request(3'd7,      8'($urandom), 2'($urandom), 8'($urandom), $urandom);
        send_request(OP_CMD,    8'($urandom), 2'($urandom), 8'($urandom), $urandom);
        drain_steps();

        // random part, mostly real requests with a sprinkling of silent ones
        counted = 0;
        while (counted < RANDOM_REQS) begin
            calm = (counted >= 120 && counted < 200);
            if (counted == 175)
                drain_steps();
            pick = $urandom_range(0, 99);
            row  = 2'($urandom);
            if (pick < 4)       op = OP_INIT;
            else if (pick < 24) op = OP_CMD;
            else if (pick < 44) op = OP_DATA;
            else if (pick < 50) op = OP_CLEAR;
            else if (pick < 66) op = OP_CURSOR;
            else if (pick < 94) op = OP_PRINT;
            else                op = 3'(6 + $urandom_range(0, 1));
            if (op == OP_CURSOR && pick < 62)
                row = 2'($urandom_range(1, 2));
            send_request(op, 8'($urandom), row, 8'($urandom), pick_number());
            if (op <= OP_PRINT && !(op == OP_CURSOR && row != ROW_ONE && row != ROW_TWO))
                counted++;
        end
        calm = 1'b0;
        drain_steps();
        repeat (120) @(posedge i_clk);

        $display("covered %0d requests (%0d silent) across all opcodes, %0d pin step beats",
                 req_cnt, silent_cnt, beat_cnt);
        $display("random source and sink stalls plus one stall-free stretch, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
